@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL file that carries concurrent checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/ckr_pkg.sv @@
// ---------------------------------------------------------------------------
// ckr_pkg: shared types, constants and keyword ROM
// Keyword text and lengths, token codes and the request/result structs.
// ---------------------------------------------------------------------------
package ckr_pkg;

  localparam int KEYWORD_COUNT   = 20;
  localparam int MAX_KEYWORD_LEN = 18;
  localparam int POS_W           = 5;
  localparam int CODE_W          = 5;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CODE_W-1:0] code_t;

  localparam pos_t        POS_MAX   = 5'd31;
  localparam logic [7:0]  CHAT_BYTE = 8'h3C;

  localparam code_t CODE_NONE          = 5'd0;
  localparam code_t CODE_CHAT          = 5'd1;
  localparam code_t CODE_FIRST_KEYWORD = 5'd2;
  localparam code_t CODE_LAST_KEYWORD  = code_t'(int'(CODE_FIRST_KEYWORD) + KEYWORD_COUNT - 1);

  typedef struct packed {
    logic       valid;
    logic [7:0] msg_byte;
    logic       is_first;
    logic       is_last;
  } step_req_t;

  typedef struct packed {
    code_t token_code;
    pos_t  argument_offset;
  } step_res_t;

  function automatic pos_t kw_len(input int k);
    case (k)
      0:       return 5'd8;
      1:       return 5'd8;
      2:       return 5'd13;
      3:       return 5'd18;
      4:       return 5'd8;
      5:       return 5'd4;
      6:       return 5'd10;
      7:       return 5'd6;
      8:       return 5'd5;
      9:       return 5'd6;
      10:      return 5'd7;
      11:      return 5'd9;
      12:      return 5'd12;
      13:      return 5'd13;
      14:      return 5'd16;
      15:      return 5'd5;
      16:      return 5'd6;
      17:      return 5'd13;
      18:      return 5'd14;
      19:      return 5'd9;
      default: return 5'd0;
    endcase
  endfunction

  // Keyword text is right-justified: the first character sits in the
  // highest occupied byte.
  function automatic logic [MAX_KEYWORD_LEN*8-1:0] kw_text(input int k);
    case (k)
      0:       return "$MyINFO ";
      1:       return "$MyPass ";
      2:       return "$MultiSearch ";
      3:       return "$MultiConnectToMe ";
      4:       return "$Search ";
      5:       return "$SR ";
      6:       return "$Supports ";
      7:       return "$Lock ";
      8:       return "$Key ";
      9:       return "$Kick ";
      10:      return "$Hello ";
      11:      return "$GetINFO ";
      12:      return "$GetNickList";
      13:      return "$ConnectToMe ";
      14:      return "$RevConnectToMe ";
      15:      return "$To: ";
      16:      return "$Quit ";
      17:      return "$OpForceMove ";
      18:      return "$ValidateNick ";
      19:      return "$BotINFO ";
      default: return '0;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input int k, input pos_t p);
    logic [MAX_KEYWORD_LEN*8-1:0] txt;
    int                           len;
    txt = kw_text(k);
    len = int'(kw_len(k));
    if (int'(p) < len) begin
      return txt[(len - 1 - int'(p))*8 +: 8];
    end
    return 8'h00;
  endfunction

endpackage

@@ rtl/ckr_match.sv @@
// ---------------------------------------------------------------------------
// ckr_match: per-byte keyword matcher
// Holds the message state and compares each byte against every keyword.
// ---------------------------------------------------------------------------
module ckr_match
  import ckr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  step_req_t req,
  output step_res_t res
);

  pos_t                     pos_r, pos_nxt;
  logic [KEYWORD_COUNT-1:0] alive_r, alive_nxt;
  logic                     chat_r, chat_nxt;

  pos_t                     pos_cur;
  pos_t                     pos_inc;
  logic [KEYWORD_COUNT-1:0] alive_cur;
  logic [KEYWORD_COUNT-1:0] alive_upd;
  logic                     chat_cur;
  logic                     chat_upd;

  always_comb begin
    // A first byte discards any partial message.
    pos_cur   = req.is_first ? '0 : pos_r;
    alive_cur = req.is_first ? '1 : alive_r;
    chat_cur  = req.is_first ? 1'b0 : chat_r;

    alive_upd = alive_cur;
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      if ((pos_cur < kw_len(k)) && (kw_char(k, pos_cur) != req.msg_byte)) begin
        alive_upd[k] = 1'b0;
      end
    end

    chat_upd = chat_cur | ((pos_cur == '0) && (req.msg_byte == CHAT_BYTE));
    pos_inc  = (pos_cur != POS_MAX) ? pos_cur + pos_t'(1) : pos_cur;

    // Lowest table index wins, so scan from the top down.
    res.token_code      = CODE_NONE;
    res.argument_offset = '0;
    if (chat_upd) begin
      res.token_code = CODE_CHAT;
    end else begin
      for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
        if (alive_upd[k] && (kw_len(k) != '0) && (kw_len(k) <= pos_inc)) begin
          res.token_code      = CODE_FIRST_KEYWORD + code_t'(k);
          res.argument_offset = kw_len(k);
        end
      end
    end

    pos_nxt   = pos_r;
    alive_nxt = alive_r;
    chat_nxt  = chat_r;
    if (req.valid) begin
      if (req.is_last) begin
        pos_nxt   = '0;
        alive_nxt = '1;
        chat_nxt  = 1'b0;
      end else begin
        pos_nxt   = pos_inc;
        alive_nxt = alive_upd;
        chat_nxt  = chat_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      alive_r <= '1;
      chat_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      alive_r <= alive_nxt;
      chat_r  <= chat_nxt;
    end
  end

endmodule

@@ rtl/command_keyword_recognizer_core.sv @@
// ---------------------------------------------------------------------------
// command_keyword_recognizer_core: command keyword recognizer
// Identifies the leading command keyword of a message and its argument offset.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Payload
//  --------+-----------+--------------------------------------------------
//  in_     | slave     | tdata: msg_byte; tuser: is_first; tlast: is_last
//  out_    | master    | tdata: token_code, argument_offset
//
// The block takes one byte request per cycle unless a last byte is held in the input
// register behind a stalled result. A byte is held in the input register, where it is
// compared against all twenty keyword ROM entries at once; the result of a last byte
// is then captured in the result register. Reset is synchronous and active low; it
// clears the message state and empties both registers. A stalled result holds only
// the last byte of the next message: other bytes keep flowing meanwhile.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module command_keyword_recognizer_core
  import ckr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic        in_tuser,   // [0] is_first
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [4:0] token_code, [9:5] argument_offset, rest zero
);

  // Input register: one byte request waiting to be matched.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_first_r;
  logic       s1_last_r;
  logic       s1_fire;
  logic       in_accept;

  // Result register.
  logic       out_valid_r, out_valid_nxt;
  step_res_t  out_res_r;

  step_req_t  req;
  step_res_t  res;

  // A non-last byte never produces a result, so it can always advance. A
  // last byte advances only when the result register is free or draining.
  assign s1_fire   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    req.valid    = s1_fire;
    req.msg_byte = s1_byte_r;
    req.is_first = s1_first_r;
    req.is_last  = s1_last_r;
  end

  ckr_match u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_fire && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r  <= in_tdata;
      s1_first_r <= in_tuser;
      s1_last_r  <= in_tlast;
    end
    if (s1_fire && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.argument_offset, out_res_r.token_code};

  // A pending result is never overwritten by the next message's result.
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, out_valid_r && !out_tready, !(s1_fire && s1_last_r))
  // Token codes stay within the defined range.
  `ASSERT_IMPLIES(a_code_range, clk, rst_n, out_valid_r, out_res_r.token_code <= CODE_LAST_KEYWORD)
  // Chat and unidentified results always report offset zero.
  `ASSERT_IMPLIES(a_zero_offset, clk, rst_n,
    out_valid_r && (out_res_r.token_code == CODE_NONE || out_res_r.token_code == CODE_CHAT),
    out_res_r.argument_offset == '0)
  // A matched keyword reports a nonzero argument offset.
  `ASSERT_IMPLIES(a_kw_offset, clk, rst_n,
    out_valid_r && (out_res_r.token_code >= CODE_FIRST_KEYWORD),
    out_res_r.argument_offset != '0)
  // A non-last byte in the input register drains on the next edge.
  `ASSERT_NEXT(a_nonlast_drains, clk, rst_n, s1_valid_r && !s1_last_r && !in_accept, !s1_valid_r)

endmodule

@@ tb/command_keyword_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// command_keyword_checker: token prediction and result scoreboard
// Follows every accepted byte request with an independent model of the
// keyword matcher. It queues the predicted token code and argument offset
// for each message and compares them with each result taken from the
// output channel.
// ---------------------------------------------------------------------------
module command_keyword_checker
  import ckr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic        in_tuser,   // [0] is_first
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [4:0] token_code, [9:5] argument_offset
  output int          error_count,
  output int          pending_results
);

  step_res_t awaited_tokens[$];

  pos_t                     next_pos;
  logic [KEYWORD_COUNT-1:0] still_possible;
  logic                     chat_flag;

  // Command table in priority order; token code is table index plus two.
  function automatic string keyword_spelling(input int k);
    case (k)
      0:       return "$MyINFO ";
      1:       return "$MyPass ";
      2:       return "$MultiSearch ";
      3:       return "$MultiConnectToMe ";
      4:       return "$Search ";
      5:       return "$SR ";
      6:       return "$Supports ";
      7:       return "$Lock ";
      8:       return "$Key ";
      9:       return "$Kick ";
      10:      return "$Hello ";
      11:      return "$GetINFO ";
      12:      return "$GetNickList";
      13:      return "$ConnectToMe ";
      14:      return "$RevConnectToMe ";
      15:      return "$To: ";
      16:      return "$Quit ";
      17:      return "$OpForceMove ";
      18:      return "$ValidateNick ";
      19:      return "$BotINFO ";
      default: return "";
    endcase
  endfunction

  task automatic restart_message();
    next_pos       = '0;
    still_possible = '1;
    chat_flag      = 1'b0;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic first, input logic last);
    string      word;
    logic [7:0] want;
    step_res_t  verdict;
    int         k;
    if (first) begin
      restart_message();
    end
    if (next_pos == '0 && b == CHAT_BYTE) begin
      chat_flag = 1'b1;
    end
    for (k = 0; k < KEYWORD_COUNT; k++) begin
      word = keyword_spelling(k);
      if (int'(next_pos) < word.len()) begin
        want = word[int'(next_pos)];
        if (want != b) begin
          still_possible[k] = 1'b0;
        end
      end
    end
    if (next_pos != POS_MAX) begin
      next_pos = next_pos + 1'b1;
    end
    if (last) begin
      verdict.token_code      = CODE_NONE;
      verdict.argument_offset = '0;
      if (chat_flag) begin
        verdict.token_code = CODE_CHAT;
      end else begin
        // Walk from the back so the earliest surviving keyword wins.
        for (k = KEYWORD_COUNT - 1; k >= 0; k--) begin
          word = keyword_spelling(k);
          if (still_possible[k] && word.len() <= int'(next_pos)) begin
            verdict.token_code      = code_t'(int'(CODE_FIRST_KEYWORD) + k);
            verdict.argument_offset = pos_t'(word.len());
          end
        end
      end
      awaited_tokens.push_back(verdict);
      restart_message();
    end
  endtask

  always @(posedge clk) begin : watch_channels
    step_res_t wanted;
    if (!rst_n) begin
      awaited_tokens.delete();
      restart_message();
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_tokens.size() == 0) begin
          $display("%0t: result with nothing expected, got tdata %h", $time, out_tdata);
          error_count = error_count + 1;
        end else begin
          wanted = awaited_tokens.pop_front();
          if (out_tdata[4:0] != wanted.token_code) begin
            $display("%0t: token_code expected %0d, got %0d",
                     $time, wanted.token_code, out_tdata[4:0]);
            error_count = error_count + 1;
          end
          if (out_tdata[9:5] != wanted.argument_offset) begin
            $display("%0t: argument_offset expected %0d, got %0d",
                     $time, wanted.argument_offset, out_tdata[9:5]);
            error_count = error_count + 1;
          end
          if (out_tdata[15:10] != '0) begin
            $display("%0t: tdata padding expected 0, got %h", $time, out_tdata[15:10]);
            error_count = error_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        absorb_byte(in_tdata, in_tuser, in_tlast);
      end
    end
    pending_results = awaited_tokens.size();
  end

endmodule

@@ tb/tb_command_keyword_recognizer_core.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_command_keyword_recognizer_core: testbench for the keyword recognizer
// Streams protocol messages into the recognizer, byte by byte, under several
// sender and receiver idling mixes, and lets a checker compare every token
// result with its own prediction.
// ---------------------------------------------------------------------------
module tb_command_keyword_recognizer_core;
  import ckr_pkg::*;

  // Generous bound, far beyond the slowest plausible correct run.
  localparam int CYCLE_LIMIT     = 400000;
  // Long receiver hold-off, long enough to back the block up completely.
  localparam int HOLD_OFF_CYCLES = 300;
  // Each random phase stops once it has sent this many bytes and results.
  localparam int PHASE_BYTES     = 150;
  localparam int PHASE_RESULTS   = 12;
  localparam int PHASE_COUNT     = 4;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;   // [7:0] msg_byte
  logic        in_tuser   = 1'b0;    // [0] is_first
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;            // [4:0] token_code, [9:5] argument_offset

  int error_count;
  int pending_results;
  int cycle_count;

  // Idling mix of the current phase, in percent of cycles.
  int sender_idle_pct;
  int receiver_stall_pct;

  // The stimulus asks for a hold-off by bumping holds_requested; the receiver
  // process counts the stretch itself.
  int holds_requested;
  int holds_done;
  int stall_left;

  int bytes_offered;
  int results_offered;
  int next_keyword;

  logic [7:0] msg_bytes[$];

  command_keyword_recognizer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  command_keyword_checker token_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_command_keyword_recognizer_core: errors");
      $finish;
    end
  end

  // Result receiver. A requested hold-off keeps tready low for a long stretch;
  // otherwise tready follows the stall mix of the current phase.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (holds_done != holds_requested) begin
      out_tready <= 1'b0;
      stall_left <= HOLD_OFF_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Offers one byte request and returns at the edge that accepts it. tvalid
  // stays high on return so back-to-back requests need no extra assignment.
  task automatic send_request(input logic [7:0] b, input logic first, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    bytes_offered++;
  endtask

  // Sends the bytes collected in msg_bytes; the first and last marks are
  // optional so that unmarked starts and abandoned messages can be built.
  task automatic send_message(input bit mark_first, input bit mark_last);
    int i;
    for (i = 0; i < msg_bytes.size(); i++) begin
      send_request(msg_bytes[i], mark_first && i == 0, mark_last && i == msg_bytes.size() - 1);
    end
    if (mark_last) begin
      results_offered++;
    end
  endtask

  // Appends the first count characters of keyword k.
  task automatic append_keyword(input int k, input int count);
    int j;
    for (j = 0; j < count; j++) begin
      msg_bytes.push_back(kw_char(k, pos_t'(j)));
    end
  endtask

  task automatic append_noise(input int count);
    int j;
    for (j = 0; j < count; j++) begin
      msg_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic append_text(input string s);
    int j;
    for (j = 0; j < s.len(); j++) begin
      msg_bytes.push_back(s[j]);
    end
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) begin
      @(posedge clk);
    end
  endtask

  // One random message. Half are well-formed commands that cycle through the
  // whole table with a random argument; the rest are truncated or corrupted
  // commands, chat lines, random noise, messages long enough to saturate the
  // byte position, and partial messages that are abandoned without a last
  // mark. About one message in ten arrives without its first mark.
  task automatic random_message();
    int kind;
    int k;
    int len;
    bit mark_first;
    bit mark_last;
    kind       = $urandom_range(99);
    k          = $urandom_range(KEYWORD_COUNT - 1);
    len        = int'(kw_len(k));
    mark_first = ($urandom_range(9) != 0);
    mark_last  = 1'b1;
    msg_bytes.delete();
    if (kind < 50) begin
      k            = next_keyword;
      next_keyword = (next_keyword + 1) % KEYWORD_COUNT;
      append_keyword(k, int'(kw_len(k)));
      append_noise($urandom_range(6));
    end else if (kind < 60) begin
      // Too short for the keyword it starts with.
      append_keyword(k, $urandom_range(len - 1, 1));
    end else if (kind < 70) begin
      // One keyword character overwritten, possibly with itself.
      append_keyword(k, len);
      append_noise($urandom_range(4));
      msg_bytes[$urandom_range(len - 1)] = 8'($urandom_range(255));
    end else if (kind < 80) begin
      msg_bytes.push_back(CHAT_BYTE);
      append_noise($urandom_range(10));
    end else if (kind < 88) begin
      append_noise($urandom_range(40, 1));
      if ($urandom_range(1) == 1) begin
        msg_bytes[0] = "$";
      end
    end else if (kind < 94) begin
      append_keyword(k, len);
      append_noise($urandom_range(45, 32) - len);
    end else begin
      append_keyword(k, $urandom_range(len, 1));
      mark_last = 1'b0;
    end
    send_message(mark_first, mark_last);
  endtask

  initial begin : stimulus
    int phase;
    int phase_bytes;
    int phase_results;

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling. A lone '<' is chat of length one.
    msg_bytes.delete();
    msg_bytes.push_back(CHAT_BYTE);
    send_message(1'b1, 1'b1);
    // A lone zero byte matches nothing.
    msg_bytes.delete();
    msg_bytes.push_back(8'h00);
    send_message(1'b1, 1'b1);
    // The shortest keyword exactly, then the same keyword one byte short.
    msg_bytes.delete();
    append_text("$SR ");
    send_message(1'b1, 1'b1);
    msg_bytes.delete();
    append_text("$SR");
    send_message(1'b1, 1'b1);
    // A zero byte where the keyword wants its final character.
    msg_bytes.delete();
    append_text("$To:");
    msg_bytes.push_back(8'h00);
    send_message(1'b1, 1'b1);
    // A partial message discarded by a new first mark.
    msg_bytes.delete();
    append_text("$Ke");
    send_message(1'b1, 1'b0);
    msg_bytes.delete();
    append_text("$Kick ");
    send_message(1'b1, 1'b1);
    // After a last byte, a message starts even without a first mark.
    msg_bytes.delete();
    append_text("$Key ");
    send_message(1'b0, 1'b1);
    drain_results();

    // Random phases: no idling, sender idling, receiver stalling, both.
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 70;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 70;
        end
        default: begin
          sender_idle_pct    = 25;
          receiver_stall_pct = 25;
        end
      endcase
      // In the first phase the receiver holds off for a long stretch while
      // the sender keeps offering, so the block backs up and drops in_tready.
      if (phase == 0) begin
        holds_requested++;
      end
      phase_bytes   = bytes_offered;
      phase_results = results_offered;
      while (bytes_offered - phase_bytes < PHASE_BYTES ||
             results_offered - phase_results < PHASE_RESULTS) begin
        random_message();
      end
      // The sender pauses here until every expected result has come.
      drain_results();
    end

    // Let the last handshakes settle before the final report.
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_command_keyword_recognizer_core: clean");
    end else begin
      $display("tb_command_keyword_recognizer_core: errors");
    end
    $finish;
  end

endmodule
